[sv/aes128_block_encrypt_assert.svh]
// Assertion macros shared by the AES-128 checker.
// No dependencies.
`ifndef AES128_BLOCK_ENCRYPT_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define AES_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[sv/aes_pkg.sv]
// Package for the AES-128 encryptor: S-box, GF helpers, round count, register addresses.
// No dependencies.
`timescale 1ns / 1ps
package aes_pkg;
    localparam int NumRounds = 10;
    localparam int KeyWords = 4 * (NumRounds + 1);
    localparam logic [1:0] RegKeyHigh = 2'd0;
    localparam logic [1:0] RegKeyLow  = 2'd1;

    function automatic logic [7:0] sbox(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r=8'h00;
        endcase
        return r;
    endfunction

    // multiply by x in GF(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // state byte i in bits [127-8i -: 8]; row i%4, column i/4
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[127 - 8*(r + 4*c) -: 8] = sbox(s[127 - 8*(r + 4*((c + r) % 4)) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_cols(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32*c -: 8];
            a1 = s[119 - 32*c -: 8];
            a2 = s[111 - 32*c -: 8];
            a3 = s[103 - 32*c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction
endpackage

[sv/aes_key_expand.sv]
// AES-128 key schedule: one round key (four words) per cycle into registers.
// Depends on aes_pkg.
`timescale 1ns / 1ps
module aes_key_expand
    import aes_pkg::*;
#(
    parameter int NUM_ROUNDS = NumRounds
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [127:0]                  i_key,
    output logic                          o_busy,
    output logic [NUM_ROUNDS:0][127:0]    o_round_keys
);
    localparam int CntW = $clog2(NUM_ROUNDS + 1);

    logic [CntW-1:0] r_cnt;
    logic            r_busy;
    logic [7:0]      r_rcon;
    logic [NUM_ROUNDS:0][127:0] r_keys;
    logic [127:0]    w_prev;
    logic [31:0]     w_t;
    logic [127:0]    w_next;

    // next round key from the previous one
    always_comb begin
        w_prev = r_keys[r_cnt - CntW'(1)];
        w_t = sbox_word({w_prev[23:0], w_prev[31:24]}) ^ {r_rcon, 24'h0};
        w_next[127:96] = w_prev[127:96] ^ w_t;
        w_next[95:64]  = w_prev[95:64] ^ w_next[127:96];
        w_next[63:32]  = w_prev[63:32] ^ w_next[95:64];
        w_next[31:0]   = w_prev[31:0] ^ w_next[63:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_rcon <= 8'h01;
        end else if (i_start) begin
            r_busy    <= 1'b1;
            r_cnt     <= CntW'(1);
            r_rcon    <= 8'h01;
            r_keys[0] <= i_key;
        end else if (r_busy) begin
            r_keys[r_cnt] <= w_next;
            r_rcon <= xtime(r_rcon);
            r_cnt  <= r_cnt + CntW'(1);
            if (r_cnt == CntW'(NUM_ROUNDS)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_round_keys = r_keys;
endmodule

[sv/aes128_block_encrypt.sv]
// AES-128 encryptor top: APB key registers, key schedule, unrolled round pipeline.
// Depends on aes_pkg and aes_key_expand.
// Blocks pass in order through stage registers r_st[0] to r_st[Stages]; o_valid follows the last.
// Throughput: one block per cycle while o_ready is high; one register stage per round, all stall together.
// After reset or a key write the schedule reloads; input is held off until it is done.
// Reset is synchronous, active low; it clears valid bits, key registers and the schedule state.
`timescale 1ns / 1ps
module aes128_block_encrypt
    import aes_pkg::*;
#(
    parameter int NUM_ROUNDS = NumRounds
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_cipher_high,
    output logic [63:0] o_cipher_low
);
    localparam int Stages = NUM_ROUNDS + 1;

    logic [63:0] r_key_high, r_key_low;
    logic        r_keys_ready, r_start;
    logic        w_wr, w_busy, w_adv;
    logic [NUM_ROUNDS:0][127:0] w_rk;
    logic [Stages:0]            r_vld;
    logic [Stages:0][127:0]     r_st;

    // register file
    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;
    always_comb begin
        unique case (paddr[3])
            RegKeyHigh[0]: prdata = r_key_high;
            default:       prdata = r_key_low;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high   <= '0;
            r_key_low    <= '0;
            r_keys_ready <= 1'b0;
            r_start      <= 1'b1;
        end else begin
            r_start <= 1'b0;
            if (w_wr && paddr[2:0] == 3'd0 && paddr[3] == RegKeyHigh[0]) begin
                r_key_high <= pwdata;
                r_start    <= 1'b1;
            end
            if (w_wr && paddr[2:0] == 3'd0 && paddr[3] == RegKeyLow[0]) begin
                r_key_low <= pwdata;
                r_start   <= 1'b1;
            end
            if (r_start || (w_wr && paddr[2:0] == 3'd0)) begin
                r_keys_ready <= 1'b0;
            end else if (!w_busy) begin
                r_keys_ready <= 1'b1;
            end
        end
    end

    aes_key_expand #(.NUM_ROUNDS(NUM_ROUNDS)) u_kexp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_start),
        .i_key        ({r_key_high, r_key_low}),
        .o_busy       (w_busy),
        .o_round_keys (w_rk)
    );

    // whole pipeline advances when the output slot is empty or the receiver is ready
    assign w_adv   = !r_vld[Stages] || i_ready;
    assign o_ready = w_adv && r_keys_ready;
    assign o_valid = r_vld[Stages];
    assign o_cipher_high = r_st[Stages][127:64];
    assign o_cipher_low  = r_st[Stages][63:0];

    // stage 0: initial key add; stage k: round k; stage NUM_ROUNDS+1: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[Stages-1:0], i_valid && r_keys_ready};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_st[0] <= {i_block_high, i_block_low} ^ w_rk[0];
            for (int k = 1; k < NUM_ROUNDS; k++) begin
                r_st[k] <= mix_cols(sub_shift(r_st[k-1])) ^ w_rk[k];
            end
            r_st[NUM_ROUNDS] <= sub_shift(r_st[NUM_ROUNDS-1]) ^ w_rk[NUM_ROUNDS];
            r_st[Stages]     <= r_st[NUM_ROUNDS];
        end
    end
endmodule

[sv/aes_checker.sv]
// Port-level checker for the AES-128 encryptor, bound to the top level.
// Depends on aes128_block_encrypt_assert.svh.
`timescale 1ns / 1ps
`include "aes128_block_encrypt_assert.svh"
module aes_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_cipher_high,
    input logic        pready
);
    `AES_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_cipher_high), "result dropped under stall")
    `AES_ASSERT_IMPL(a_ready_stall, i_clk, i_rst_n, o_valid && !i_ready, !o_ready, "input taken while output stalled")
    `AES_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && !o_ready, i_valid, "input transfer withdrawn while waiting")
    `AES_ASSERT_IMPL(a_pready, i_clk, i_rst_n, 1'b1, pready, "pready low")
endmodule

bind aes128_block_encrypt aes_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_cipher_high(o_cipher_high), .pready(pready)
);

[tb/testbench.sv]
// Self-checking testbench for the AES-128 encryptor: writes keys over APB, sends
// plaintext blocks and compares each ciphertext against a cipher model built here.
// Depends on aes128_block_encrypt only.
`timescale 1ns / 1ps
module testbench;
    localparam int RoundWords  = 44;
    localparam int PipeDepth   = 16;   // 12 register stages plus margin
    localparam int WatchLimit  = 20000;
    localparam logic [3:0] AddrKeyHigh = 4'd0;
    localparam logic [3:0] AddrKeyLow  = 4'd8;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } block_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata, prdata;
    logic        pready;
    logic        i_valid, o_ready;
    logic [63:0] i_block_high, i_block_low;
    logic        o_valid, i_ready;
    logic [63:0] o_cipher_high, o_cipher_low;

    aes128_block_encrypt u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_block_high(i_block_high), .i_block_low(i_block_low),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_cipher_high(o_cipher_high), .o_cipher_low(o_cipher_low)
    );

    // Cipher model state
    logic [7:0]  sub_table [256];
    logic [63:0] key_hi_q, key_lo_q;
    logic [31:0] sched_words [RoundWords];
    bit          sched_valid;
    block_t      cipher_q [$];
    int          fail_count;
    int          tx_idle_pct, rx_idle_pct;
    bit          hold_req;
    int          hold_left;
    int          quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [7:0] gf_dbl(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) p ^= a;
            a = gf_dbl(a);
        end
        return p;
    endfunction

    // S-box from the field inverse and the affine map
    task automatic build_sub_table();
        logic [7:0] inv, s;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            sub_table[x] = s;
        end
    endtask

    function automatic void expand_schedule();
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        sched_words[0] = key_hi_q[63:32];
        sched_words[1] = key_hi_q[31:0];
        sched_words[2] = key_lo_q[63:32];
        sched_words[3] = key_lo_q[31:0];
        for (int w = 4; w < RoundWords; w++) begin
            t = sched_words[w-1];
            if (w % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {sub_table[t[31:24]] ^ rc, sub_table[t[23:16]],
                     sub_table[t[15:8]], sub_table[t[7:0]]};
                rc = gf_dbl(rc);
            end
            sched_words[w] = sched_words[w-4] ^ t;
        end
        sched_valid = 1'b1;
    endfunction

    // state byte i sits at bits [127-8i -: 8]; row i%4, column i/4
    function automatic logic [127:0] encrypt_block(input logic [127:0] pt);
        logic [127:0] s, t;
        logic [7:0]   a0, a1, a2, a3, al;
        if (!sched_valid) expand_schedule();
        s = pt ^ {sched_words[0], sched_words[1], sched_words[2], sched_words[3]};
        for (int rnd = 1; rnd <= 10; rnd++) begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    t[127 - 8*(r + 4*c) -: 8] =
                        sub_table[s[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
            s = t;
            if (rnd < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[127 - 32*c -: 8];
                    a1 = s[119 - 32*c -: 8];
                    a2 = s[111 - 32*c -: 8];
                    a3 = s[103 - 32*c -: 8];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    s[127 - 32*c -: 8] = a0 ^ al ^ gf_dbl(a0 ^ a1);
                    s[119 - 32*c -: 8] = a1 ^ al ^ gf_dbl(a1 ^ a2);
                    s[111 - 32*c -: 8] = a2 ^ al ^ gf_dbl(a2 ^ a3);
                    s[103 - 32*c -: 8] = a3 ^ al ^ gf_dbl(a3 ^ a0);
                end
            end
            s ^= {sched_words[4*rnd], sched_words[4*rnd+1],
                  sched_words[4*rnd+2], sched_words[4*rnd+3]};
        end
        return s;
    endfunction

    // Input side: predict on every accepted transfer
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            cipher_q.push_back(encrypt_block({i_block_high, i_block_low}));
    end

    // Output side: compare each accepted transfer with the oldest prediction
    always @(posedge i_clk) begin
        block_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (cipher_q.size() == 0) begin
                $display("%0t: unexpected result %h_%h", $time, o_cipher_high, o_cipher_low);
                fail_count++;
            end else begin
                want = cipher_q.pop_front();
                if (want.hi !== o_cipher_high) begin
                    $display("%0t: cipher_high expected %h actual %h",
                             $time, want.hi, o_cipher_high);
                    fail_count++;
                end
                if (want.lo !== o_cipher_low) begin
                    $display("%0t: cipher_low expected %h actual %h",
                             $time, want.lo, o_cipher_low);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left <= 300;
            i_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog on cycles with no transfer anywhere
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_block_high <= hi;
        i_block_low  <= lo;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (cipher_q.size() != 0) @(posedge i_clk);
        repeat (PipeDepth) @(posedge i_clk);
    endtask

    // APB write; only called once the pipeline has drained
    task automatic write_key(input logic [3:0] addr, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == AddrKeyHigh) key_hi_q = value;
        else key_lo_q = value;
        sched_valid = 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Data before any key write runs under the all-zero key
    task automatic test_reset_key();
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        drain();
    endtask

    // Known vector, field extremes, single ones at every ninth bit, extreme keys and half-key rewrites
    task automatic test_directed();
        write_key(AddrKeyHigh, 64'h0001020304050607);
        write_key(AddrKeyLow, 64'h08090a0b0c0d0e0f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_block('1, 64'h0);
        send_block(64'h8000000000000000, 64'h1);
        for (int b = 0; b < 64; b += 9)
            send_block(64'h1 << b, 64'h1 << (63 - b));
        drain();
        // extreme keys
        write_key(AddrKeyHigh, '1);
        write_key(AddrKeyLow, '1);
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        drain();
        // only one half rewritten: the other keeps its value
        write_key(AddrKeyLow, 64'h0);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
        drain();
        write_key(AddrKeyHigh, 64'h0);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
        drain();
    endtask

    task automatic test_random(input int tx_pct, input int rx_pct, input int count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        write_key(AddrKeyHigh, rand64());
        write_key(AddrKeyLow, rand64());
        for (int n = 0; n < count; n++)
            send_block(rand64(), rand64());
        drain();
    endtask

    // Long receiver hold-off while the sender keeps offering back to back
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        for (int n = 0; n < 40; n++)
            send_block(rand64(), rand64());
        drain();
    endtask

    initial begin
        fail_count   = 0;
        quiet_cycles = 0;
        hold_req     = 1'b0;
        hold_left    = 0;
        tx_idle_pct  = 25;
        rx_idle_pct  = 87;
        key_hi_q     = 64'h0;
        key_lo_q     = 64'h0;
        sched_valid  = 1'b0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = 4'h0;
        pwdata       = 64'h0;
        i_valid      = 1'b0;
        i_block_high = 64'h0;
        i_block_low  = 64'h0;
        i_ready      = 1'b0;
        build_sub_table();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_key();
        test_directed();
        test_random(25, 87, 130);
        test_random(87, 25, 130);
        test_random(0, 0, 130);
        test_backpressure();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
